>>> hdl/lpabis_pkg.sv
// types and codes for the length-prefixed abis/ip deframer
// no dependencies; used by lpabis_parser and the top level
package lpabis_pkg;

    typedef enum logic [1:0] {
        HP_IGNORED = 2'd0,
        HP_LENGTH  = 2'd1,
        HP_PROTO   = 2'd2,
        HP_PAYLOAD = 2'd3
    } t_hdr_pos;

    typedef enum logic [2:0] {
        PH_MSG_TYPE  = 3'd0,
        PH_ATTR_TYPE = 3'd1,
        PH_ATTR_LEN  = 3'd2,
        PH_TAG       = 3'd3,
        PH_STRING    = 3'd4,
        PH_TAG_ONLY  = 3'd5,
        PH_UNKNOWN   = 3'd6,
        PH_OTHER     = 3'd7
    } t_ccm_phase;

    localparam logic [3:0] ROLE_HDR_IGNORED = 4'd0;
    localparam logic [3:0] ROLE_LENGTH      = 4'd1;
    localparam logic [3:0] ROLE_PROTO       = 4'd2;
    localparam logic [3:0] ROLE_PAYLOAD     = 4'd3;
    localparam logic [3:0] ROLE_MSG_TYPE    = 4'd4;
    localparam logic [3:0] ROLE_ATTR_TYPE   = 4'd5;
    localparam logic [3:0] ROLE_ATTR_LEN    = 4'd6;
    localparam logic [3:0] ROLE_TAG         = 4'd7;
    localparam logic [3:0] ROLE_STRING      = 4'd8;
    localparam logic [3:0] ROLE_CCM_OTHER   = 4'd9;
    localparam logic [3:0] ROLE_UNKNOWN     = 4'd10;

    localparam logic [1:0] CH_RSL     = 2'd0;
    localparam logic [1:0] CH_IPA     = 2'd1;
    localparam logic [1:0] CH_OML     = 2'd2;
    localparam logic [1:0] CH_UNKNOWN = 2'd3;

    localparam logic [7:0] PROTO_RSL = 8'h00;
    localparam logic [7:0] PROTO_IPA = 8'hfe;
    localparam logic [7:0] PROTO_OML = 8'hff;

    localparam logic [7:0] MSG_ID_REQ  = 8'h04;
    localparam logic [7:0] MSG_ID_RESP = 8'h05;

    localparam logic [7:0] ATTR_LEN_PREFIXED = 8'h00;
    localparam logic [7:0] ATTR_TAG_ONLY     = 8'h01;

    typedef struct packed {
        logic [3:0] role;
        logic [1:0] channel;
        logic       frame_end;
    } t_label;

endpackage

>>> hdl/lpabis_parser.sv
// frame header tracker and ipa attribute parser: labels one word per enable
// depends on lpabis_pkg
module lpabis_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [7:0]            i_byte,
    output lpabis_pkg::t_label    o_label
);

    lpabis_pkg::t_hdr_pos   r_hdr, n_hdr;
    lpabis_pkg::t_ccm_phase r_phase, n_phase;
    logic [7:0]             r_payload_left, n_payload_left;
    logic [7:0]             r_attr_left, n_attr_left;
    logic [1:0]             r_chan, n_chan;
    logic [1:0]             proto_chan;
    logic [7:0]             attr_dec;

    always_comb begin
        case (i_byte)
            lpabis_pkg::PROTO_RSL: proto_chan = lpabis_pkg::CH_RSL;
            lpabis_pkg::PROTO_IPA: proto_chan = lpabis_pkg::CH_IPA;
            lpabis_pkg::PROTO_OML: proto_chan = lpabis_pkg::CH_OML;
            default:               proto_chan = lpabis_pkg::CH_UNKNOWN;
        endcase
    end

    assign attr_dec = r_attr_left - 8'd1;

    // next state
    always_comb begin
        n_hdr          = r_hdr;
        n_phase        = r_phase;
        n_payload_left = r_payload_left;
        n_attr_left    = r_attr_left;
        n_chan         = r_chan;
        if (i_en) begin
            case (r_hdr)
                lpabis_pkg::HP_IGNORED: begin
                    n_hdr = lpabis_pkg::HP_LENGTH;
                end
                lpabis_pkg::HP_LENGTH: begin
                    n_payload_left = i_byte;
                    n_hdr          = lpabis_pkg::HP_PROTO;
                end
                lpabis_pkg::HP_PROTO: begin
                    n_chan      = proto_chan;
                    n_phase     = lpabis_pkg::PH_MSG_TYPE;
                    n_attr_left = 8'd0;
                    n_hdr       = (r_payload_left == 8'd0) ? lpabis_pkg::HP_IGNORED
                                                           : lpabis_pkg::HP_PAYLOAD;
                end
                default: begin
                    n_payload_left = r_payload_left - 8'd1;
                    if (r_payload_left == 8'd1) begin
                        n_hdr = lpabis_pkg::HP_IGNORED;
                    end
                    if (r_chan == lpabis_pkg::CH_IPA) begin
                        case (r_phase)
                            lpabis_pkg::PH_MSG_TYPE: begin
                                n_phase = (i_byte == lpabis_pkg::MSG_ID_REQ ||
                                           i_byte == lpabis_pkg::MSG_ID_RESP)
                                          ? lpabis_pkg::PH_ATTR_TYPE : lpabis_pkg::PH_OTHER;
                            end
                            lpabis_pkg::PH_ATTR_TYPE: begin
                                if (i_byte == lpabis_pkg::ATTR_LEN_PREFIXED) begin
                                    n_phase = lpabis_pkg::PH_ATTR_LEN;
                                end else if (i_byte == lpabis_pkg::ATTR_TAG_ONLY) begin
                                    n_phase = lpabis_pkg::PH_TAG_ONLY;
                                end else begin
                                    n_phase = lpabis_pkg::PH_UNKNOWN;
                                end
                            end
                            lpabis_pkg::PH_ATTR_LEN: begin
                                n_attr_left = i_byte;
                                n_phase     = (i_byte == 8'd0) ? lpabis_pkg::PH_ATTR_TYPE
                                                               : lpabis_pkg::PH_TAG;
                            end
                            lpabis_pkg::PH_TAG: begin
                                n_attr_left = attr_dec;
                                n_phase     = (attr_dec == 8'd0) ? lpabis_pkg::PH_ATTR_TYPE
                                                                 : lpabis_pkg::PH_STRING;
                            end
                            lpabis_pkg::PH_STRING: begin
                                n_attr_left = attr_dec;
                                if (attr_dec == 8'd0) begin
                                    n_phase = lpabis_pkg::PH_ATTR_TYPE;
                                end
                            end
                            lpabis_pkg::PH_TAG_ONLY,
                            lpabis_pkg::PH_UNKNOWN: begin
                                n_phase = lpabis_pkg::PH_ATTR_TYPE;
                            end
                            default: begin
                                n_phase = r_phase;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        o_label.role      = lpabis_pkg::ROLE_HDR_IGNORED;
        o_label.channel   = lpabis_pkg::CH_UNKNOWN;
        o_label.frame_end = 1'b0;
        case (r_hdr)
            lpabis_pkg::HP_IGNORED: begin
                o_label.role = lpabis_pkg::ROLE_HDR_IGNORED;
            end
            lpabis_pkg::HP_LENGTH: begin
                o_label.role = lpabis_pkg::ROLE_LENGTH;
            end
            lpabis_pkg::HP_PROTO: begin
                o_label.role      = lpabis_pkg::ROLE_PROTO;
                o_label.channel   = proto_chan;
                o_label.frame_end = (r_payload_left == 8'd0);
            end
            default: begin
                o_label.channel   = r_chan;
                o_label.frame_end = (r_payload_left == 8'd1);
                if (r_chan != lpabis_pkg::CH_IPA) begin
                    o_label.role = lpabis_pkg::ROLE_PAYLOAD;
                end else begin
                    case (r_phase)
                        lpabis_pkg::PH_MSG_TYPE:  o_label.role = lpabis_pkg::ROLE_MSG_TYPE;
                        lpabis_pkg::PH_ATTR_TYPE: o_label.role = lpabis_pkg::ROLE_ATTR_TYPE;
                        lpabis_pkg::PH_ATTR_LEN:  o_label.role = lpabis_pkg::ROLE_ATTR_LEN;
                        lpabis_pkg::PH_TAG:       o_label.role = lpabis_pkg::ROLE_TAG;
                        lpabis_pkg::PH_STRING:    o_label.role = lpabis_pkg::ROLE_STRING;
                        lpabis_pkg::PH_TAG_ONLY:  o_label.role = lpabis_pkg::ROLE_TAG;
                        lpabis_pkg::PH_UNKNOWN:   o_label.role = lpabis_pkg::ROLE_UNKNOWN;
                        default:                  o_label.role = lpabis_pkg::ROLE_CCM_OTHER;
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr          <= lpabis_pkg::HP_IGNORED;
            r_phase        <= lpabis_pkg::PH_MSG_TYPE;
            r_payload_left <= 8'd0;
            r_attr_left    <= 8'd0;
            r_chan         <= lpabis_pkg::CH_RSL;
        end else begin
            r_hdr          <= n_hdr;
            r_phase        <= n_phase;
            r_payload_left <= n_payload_left;
            r_attr_left    <= n_attr_left;
            r_chan         <= n_chan;
        end
    end

endmodule

>>> hdl/length_prefixed_abis_ip_deframer.sv
// top level of the length-prefixed abis/ip deframer: input and result registers
// depends on lpabis_pkg and lpabis_parser
//
// input channel: i_valid / o_stall carry one stream word (i_data_byte) per
// accepted cycle. output channel: o_valid / i_stall carry one labelled word
// per input word: o_out_byte, o_byte_role, o_channel, o_frame_end.
// each word goes through an input register, the header and attribute
// parser, and a result register, whose valid bit drives o_valid.
// one word is taken every clock while the output side keeps up; the rate
// is set by the single parser pass between the two registers.
// when i_stall holds a result, both registers and the parser state freeze
// and o_stall rises in the same cycle, so no word is lost or repeated.
// synchronous active-low reset empties both registers and returns the
// parser to the first header byte of a frame.
module length_prefixed_abis_ip_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic [3:0] o_byte_role,
    output logic [1:0] o_channel,
    output logic       o_frame_end
);

    logic               adv;
    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    lpabis_pkg::t_label r_out_label;
    lpabis_pkg::t_label label;

    assign adv     = !r_out_valid || !i_stall;
    assign o_stall = !adv;

    lpabis_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv && r_in_valid),
        .i_byte  (r_in_byte),
        .o_label (label)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_in_valid  <= i_valid;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_in_byte   <= i_data_byte;
            r_out_byte  <= r_in_byte;
            r_out_label <= label;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_byte_role = r_out_label.role;
    assign o_channel   = r_out_label.channel;
    assign o_frame_end = r_out_label.frame_end;

    a_hdr_unlabelled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_byte_role == lpabis_pkg::ROLE_HDR_IGNORED ||
                    o_byte_role == lpabis_pkg::ROLE_LENGTH)
        |-> o_channel == lpabis_pkg::CH_UNKNOWN && !o_frame_end)
        else $error("header word carries channel or frame end");

    a_ccm_roles_on_ipa: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_byte_role >= lpabis_pkg::ROLE_MSG_TYPE
        |-> o_channel == lpabis_pkg::CH_IPA)
        else $error("ipa attribute role on non-ipa frame");

    a_after_end_is_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_frame_end && r_in_valid
        |=> o_valid && o_byte_role == lpabis_pkg::ROLE_HDR_IGNORED)
        else $error("word after frame end is not a new header");

endmodule

>>> tb/tb_length_prefixed_abis_ip_deframer.sv
`timescale 1ns / 100ps
// testbench for length_prefixed_abis_ip_deframer: frames pushed word by word, every
// labelled word checked against a behavioral predictor of the header and attribute parser
// depends on lpabis_pkg and the deframer rtl
module tb_length_prefixed_abis_ip_deframer;

    typedef struct packed {
        logic [7:0]         data;
        lpabis_pkg::t_label lab;
    } t_labelled_word;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_stall     = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic [3:0] o_byte_role;
    logic [1:0] o_channel;
    logic       o_frame_end;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int words_sent     = 0;
    int mismatch_count = 0;

    t_labelled_word labelled_words_due[$];

    lpabis_pkg::t_hdr_pos   hdr_pos;
    lpabis_pkg::t_ccm_phase ccm_phase;
    logic [7:0]             frame_left;
    logic [7:0]             attr_left;
    logic [1:0]             frame_chan;
    logic                   ident_msg;

    length_prefixed_abis_ip_deframer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_byte_role (o_byte_role),
        .o_channel   (o_channel),
        .o_frame_end (o_frame_end)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // role of a payload word inside an ipa frame
    function automatic logic [3:0] ipa_role(input logic [7:0] b);
        logic [3:0] role;
        role = lpabis_pkg::ROLE_CCM_OTHER;
        case (ccm_phase)
            lpabis_pkg::PH_MSG_TYPE: begin
                role = lpabis_pkg::ROLE_MSG_TYPE;
                ident_msg = (b == lpabis_pkg::MSG_ID_REQ) || (b == lpabis_pkg::MSG_ID_RESP);
                if (ident_msg) ccm_phase = lpabis_pkg::PH_ATTR_TYPE;
                else ccm_phase = lpabis_pkg::PH_OTHER;
            end
            lpabis_pkg::PH_ATTR_TYPE: begin
                role = lpabis_pkg::ROLE_ATTR_TYPE;
                if (b == lpabis_pkg::ATTR_LEN_PREFIXED) ccm_phase = lpabis_pkg::PH_ATTR_LEN;
                else if (b == lpabis_pkg::ATTR_TAG_ONLY) ccm_phase = lpabis_pkg::PH_TAG_ONLY;
                else ccm_phase = lpabis_pkg::PH_UNKNOWN;
            end
            lpabis_pkg::PH_ATTR_LEN: begin
                role = lpabis_pkg::ROLE_ATTR_LEN;
                attr_left = b;
                if (b == 8'h00) ccm_phase = lpabis_pkg::PH_ATTR_TYPE;
                else ccm_phase = lpabis_pkg::PH_TAG;
            end
            lpabis_pkg::PH_TAG: begin
                role = lpabis_pkg::ROLE_TAG;
                attr_left = attr_left - 8'd1;
                if (attr_left == 8'h00) ccm_phase = lpabis_pkg::PH_ATTR_TYPE;
                else ccm_phase = lpabis_pkg::PH_STRING;
            end
            lpabis_pkg::PH_STRING: begin
                role = lpabis_pkg::ROLE_STRING;
                attr_left = attr_left - 8'd1;
                if (attr_left == 8'h00) ccm_phase = lpabis_pkg::PH_ATTR_TYPE;
            end
            lpabis_pkg::PH_TAG_ONLY: begin
                role = lpabis_pkg::ROLE_TAG;
                ccm_phase = lpabis_pkg::PH_ATTR_TYPE;
            end
            lpabis_pkg::PH_UNKNOWN: begin
                role = lpabis_pkg::ROLE_UNKNOWN;
                ccm_phase = lpabis_pkg::PH_ATTR_TYPE;
            end
            default: role = lpabis_pkg::ROLE_CCM_OTHER;
        endcase
        return role;
    endfunction

    function automatic lpabis_pkg::t_label label_word(input logic [7:0] b);
        lpabis_pkg::t_label lab;
        lab.role      = lpabis_pkg::ROLE_HDR_IGNORED;
        lab.channel   = lpabis_pkg::CH_UNKNOWN;
        lab.frame_end = 1'b0;
        case (hdr_pos)
            lpabis_pkg::HP_IGNORED: hdr_pos = lpabis_pkg::HP_LENGTH;
            lpabis_pkg::HP_LENGTH: begin
                lab.role   = lpabis_pkg::ROLE_LENGTH;
                frame_left = b;
                hdr_pos    = lpabis_pkg::HP_PROTO;
            end
            lpabis_pkg::HP_PROTO: begin
                lab.role = lpabis_pkg::ROLE_PROTO;
                case (b)
                    lpabis_pkg::PROTO_RSL: frame_chan = lpabis_pkg::CH_RSL;
                    lpabis_pkg::PROTO_IPA: frame_chan = lpabis_pkg::CH_IPA;
                    lpabis_pkg::PROTO_OML: frame_chan = lpabis_pkg::CH_OML;
                    default:               frame_chan = lpabis_pkg::CH_UNKNOWN;
                endcase
                lab.channel = frame_chan;
                ccm_phase   = lpabis_pkg::PH_MSG_TYPE;
                attr_left   = 8'h00;
                ident_msg   = 1'b0;
                if (frame_left == 8'h00) begin
                    lab.frame_end = 1'b1;
                    hdr_pos       = lpabis_pkg::HP_IGNORED;
                end else begin
                    hdr_pos = lpabis_pkg::HP_PAYLOAD;
                end
            end
            default: begin
                lab.channel = frame_chan;
                if (frame_chan == lpabis_pkg::CH_IPA) lab.role = ipa_role(b);
                else lab.role = lpabis_pkg::ROLE_PAYLOAD;
                frame_left = frame_left - 8'd1;
                if (frame_left == 8'h00) begin
                    lab.frame_end = 1'b1;
                    hdr_pos       = lpabis_pkg::HP_IGNORED;
                end
            end
        endcase
        return lab;
    endfunction

    task automatic send_word(input logic [7:0] b);
        t_labelled_word due;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        due.data = b;
        due.lab  = label_word(b);
        labelled_words_due.push_back(due);
        words_sent++;
    endtask

    task automatic wait_until_drained();
        i_valid <= 1'b0;
        while (labelled_words_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : check_results
        t_labelled_word due;
        if (i_rst_n && o_valid && !i_stall) begin
            if (labelled_words_due.size() == 0) begin
                $error("o_out_byte: expected no word, got %02h", o_out_byte);
                mismatch_count++;
            end else begin
                due = labelled_words_due.pop_front();
                if (o_out_byte !== due.data) begin
                    $error("o_out_byte: expected %02h, got %02h", due.data, o_out_byte);
                    mismatch_count++;
                end
                if (o_byte_role !== due.lab.role) begin
                    $error("o_byte_role: expected %0d, got %0d", due.lab.role, o_byte_role);
                    mismatch_count++;
                end
                if (o_channel !== due.lab.channel) begin
                    $error("o_channel: expected %0d, got %0d", due.lab.channel, o_channel);
                    mismatch_count++;
                end
                if (o_frame_end !== due.lab.frame_end) begin
                    $error("o_frame_end: expected %0b, got %0b", due.lab.frame_end,
                           o_frame_end);
                    mismatch_count++;
                end
            end
        end
    end

    // oml with one payload word, then empty ipa, rsl and unknown-protocol frames
    task automatic test_headers_and_channels();
        logic [7:0] seq[$];
        seq = '{8'hff, 8'h01, lpabis_pkg::PROTO_OML, 8'h00,
                8'h00, 8'h00, lpabis_pkg::PROTO_IPA,
                8'h00, 8'h00, lpabis_pkg::PROTO_RSL,
                8'h80, 8'h00, 8'h3c};
        foreach (seq[i]) send_word(seq[i]);
    endtask

    // zero-length, tag-only and unknown attributes, frame cut inside a string
    task automatic test_identity_attributes();
        logic [7:0] seq[$];
        seq = '{8'h00, 8'h0b, lpabis_pkg::PROTO_IPA, lpabis_pkg::MSG_ID_RESP,
                lpabis_pkg::ATTR_LEN_PREFIXED, 8'h00,
                lpabis_pkg::ATTR_TAG_ONLY, 8'h43,
                8'h7f, 8'hee,
                lpabis_pkg::ATTR_LEN_PREFIXED, 8'h03, 8'h41, 8'h42};
        foreach (seq[i]) send_word(seq[i]);
    endtask

    task automatic test_other_ipa_message();
        logic [7:0] seq[$];
        seq = '{8'h00, 8'h02, lpabis_pkg::PROTO_IPA, 8'h06, 8'h99};
        foreach (seq[i]) send_word(seq[i]);
    endtask

    task automatic send_random_frame();
        logic [7:0] body[$];
        logic [7:0] proto;
        int         kind;
        int         len;
        int         alen;
        int         cut;
        kind = $urandom_range(99);
        if (kind < 55) begin
            proto = lpabis_pkg::PROTO_IPA;
            if ($urandom_range(99) < 75) begin
                body.push_back(8'($urandom_range(lpabis_pkg::MSG_ID_RESP,
                                                 lpabis_pkg::MSG_ID_REQ)));
            end else begin
                body.push_back(8'($urandom_range(255)));
            end
            if (body[0] == lpabis_pkg::MSG_ID_REQ || body[0] == lpabis_pkg::MSG_ID_RESP) begin
                repeat ($urandom_range(4)) begin
                    case ($urandom_range(2))
                        0: begin
                            alen = ($urandom_range(4) == 0) ? 0 : $urandom_range(6, 1);
                            body.push_back(lpabis_pkg::ATTR_LEN_PREFIXED);
                            body.push_back(8'(alen));
                            repeat (alen) body.push_back(8'($urandom_range(255)));
                        end
                        1: begin
                            body.push_back(lpabis_pkg::ATTR_TAG_ONLY);
                            body.push_back(8'($urandom_range(255)));
                        end
                        default: begin
                            body.push_back(8'($urandom_range(255, 2)));
                            body.push_back(8'($urandom_range(255)));
                        end
                    endcase
                end
            end else begin
                repeat ($urandom_range(6)) body.push_back(8'($urandom_range(255)));
            end
            // truncated or padded frames now and then
            cut = $urandom_range(99);
            if (cut < 12) begin
                len = $urandom_range(body.size());
            end else begin
                if (cut < 18) begin
                    repeat ($urandom_range(4, 1)) body.push_back(8'($urandom_range(255)));
                end
                len = body.size();
            end
        end else begin
            if (kind < 65) proto = lpabis_pkg::PROTO_RSL;
            else if (kind < 75) proto = lpabis_pkg::PROTO_OML;
            else proto = 8'($urandom_range(255));
            len = ($urandom_range(24) == 0) ? $urandom_range(255) : $urandom_range(12);
            repeat (len) body.push_back(8'($urandom_range(255)));
        end
        send_word(8'($urandom_range(255)));
        send_word(8'(len));
        send_word(proto);
        for (int i = 0; i < len; i++) send_word(body[i]);
    endtask

    task automatic test_random_stream(input int sender_pct, input int receiver_pct,
                                      input int count);
        int target;
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
        target         = words_sent + count;
        while (words_sent < target) send_random_frame();
        wait_until_drained();
    endtask

    initial begin
        hdr_pos    = lpabis_pkg::HP_IGNORED;
        ccm_phase  = lpabis_pkg::PH_MSG_TYPE;
        frame_left = 8'h00;
        attr_left  = 8'h00;
        frame_chan = lpabis_pkg::CH_RSL;
        ident_msg  = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct  = 18;
        recv_stall_pct = 72;
        test_headers_and_channels();
        test_identity_attributes();
        test_other_ipa_message();
        wait_until_drained();
        test_random_stream(18, 72, 300);
        test_random_stream(72, 18, 300);
        test_random_stream(0, 0, 300);
        if (mismatch_count == 0 && labelled_words_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
